FILE: rtl/lfe_pkg.sv
`timescale 1ns / 1ps

package lfe_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int GAMMA_W = 17;
  localparam int ROM_DEPTH = 256;

  localparam logic [2:0] CFG_GLOBAL_BRIGHTNESS = 3'd0;
  localparam logic [2:0] CFG_BRIDGE_ORDER      = 3'd1;
  localparam logic [2:0] CFG_RED_SCALE         = 3'd2;
  localparam logic [2:0] CFG_GREEN_SCALE       = 3'd3;
  localparam logic [2:0] CFG_BLUE_SCALE        = 3'd4;

  localparam logic [4:0] BRIGHTNESS_RESET = 5'd31;
  localparam logic [7:0] SCALE_RESET      = 8'hFF;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_PIXEL = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  localparam logic [31:0] START_WORD  = 32'h0000_0000;
  localparam logic [31:0] END_WORD    = 32'hFFFF_FFFF;
  localparam logic [7:0]  HEADER_MARK = 8'hE0;

  typedef logic [GAMMA_W-1:0] gamma_rom_t [ROM_DEPTH];

  // One classified pixel waiting for the word sequencer.
  typedef struct packed {
    logic        need_start;
    logic        last;
    logic [31:0] pixel_word;
  } lfe_entry_t;

  typedef struct packed {
    logic       not_empty;
    lfe_entry_t head;
  } lfe_queue_status_t;

  // Fractions of 65536 for (c/255)^(gamma_x100/100), rounded to nearest.
  function automatic gamma_rom_t build_gamma_rom(input int gamma_x100);
    gamma_rom_t rom;
    real        expo;
    real        v;
    expo = real'(gamma_x100) / 100.0;
    for (int c = 0; c < ROM_DEPTH; c++) begin
      if (c == 0) begin
        v = 0.0;
      end else begin
        v = $pow(real'(c) / 255.0, expo) * 65536.0;
      end
      rom[c] = GAMMA_W'($rtoi(v + 0.5));
    end
    return rom;
  endfunction

endpackage

FILE: rtl/lfe_front.sv
`timescale 1ns / 1ps

module lfe_front #(
  parameter int GAMMA_X100 = 280
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    red,
  input  logic [7:0]                    green,
  input  logic [7:0]                    blue,
  input  logic [7:0]                    alpha,
  input  logic                          last_pixel,
  input  logic                          cfg_en,
  input  logic [2:0]                    cfg_index,
  input  logic [7:0]                    cfg_data,
  input  logic [lfe_pkg::QUEUE_CNT_W-1:0] queue_count,
  output logic                          push,
  output lfe_pkg::lfe_entry_t           push_entry
);
  import lfe_pkg::*;

  localparam gamma_rom_t GAMMA_ROM = build_gamma_rom(GAMMA_X100);

  logic [4:0] global_brightness;
  logic       bridge_order;
  logic [7:0] red_scale;
  logic [7:0] green_scale;
  logic [7:0] blue_scale;
  logic       in_frame;

  logic               s1_valid;
  logic               s1_need_start;
  logic               s1_last;
  logic [GAMMA_W-1:0] s1_gamma_r;
  logic [GAMMA_W-1:0] s1_gamma_g;
  logic [GAMMA_W-1:0] s1_gamma_b;
  logic [12:0]        s1_bright_prod;

  logic                 accept;
  logic [QUEUE_CNT_W:0] occupancy;
  logic [24:0]          prod_r;
  logic [24:0]          prod_g;
  logic [24:0]          prod_b;
  logic [13:0]          bright_sum;
  logic [4:0]           bright;
  logic [31:0]          word_raw;

  // Every accepted pixel is owed one queue slot, so the pipeline register
  // never has to wait on the queue.
  assign occupancy = {1'b0, queue_count} + (QUEUE_CNT_W + 1)'(s1_valid);
  assign in_stall  = occupancy >= (QUEUE_CNT_W + 1)'(QUEUE_DEPTH);
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      global_brightness <= BRIGHTNESS_RESET;
      bridge_order      <= 1'b0;
      red_scale         <= SCALE_RESET;
      green_scale       <= SCALE_RESET;
      blue_scale        <= SCALE_RESET;
    end else if (cfg_en) begin
      case (cfg_index)
        CFG_GLOBAL_BRIGHTNESS: global_brightness <= cfg_data[4:0];
        CFG_BRIDGE_ORDER:      bridge_order      <= cfg_data[0];
        CFG_RED_SCALE:         red_scale         <= cfg_data;
        CFG_GREEN_SCALE:       green_scale       <= cfg_data;
        CFG_BLUE_SCALE:        blue_scale        <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame <= 1'b0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        in_frame <= !last_pixel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_need_start  <= !in_frame;
      s1_last        <= last_pixel;
      s1_gamma_r     <= GAMMA_ROM[red];
      s1_gamma_g     <= GAMMA_ROM[green];
      s1_gamma_b     <= GAMMA_ROM[blue];
      s1_bright_prod <= 13'(alpha) * 13'(global_brightness);
    end
  end

  assign prod_r = 25'(s1_gamma_r) * 25'(red_scale);
  assign prod_g = 25'(s1_gamma_g) * 25'(green_scale);
  assign prod_b = 25'(s1_gamma_b) * 25'(blue_scale);

  // Division by 255 for the 13-bit products.
  assign bright_sum = 14'(s1_bright_prod) + 14'd1 + 14'(s1_bright_prod[12:8]);
  assign bright     = bright_sum[12:8];

  assign word_raw = {HEADER_MARK | {3'b000, bright}, prod_b[23:16], prod_g[23:16],
                     prod_r[23:16]};

  assign push                  = s1_valid;
  assign push_entry.need_start = s1_need_start;
  assign push_entry.last       = s1_last;
  assign push_entry.pixel_word = bridge_order ? {word_raw[23:0], word_raw[31:24]}
                                              : word_raw;

endmodule

FILE: rtl/lfe_queue.sv
`timescale 1ns / 1ps

module lfe_queue (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  lfe_pkg::lfe_entry_t             push_entry,
  input  logic                            pop,
  output lfe_pkg::lfe_queue_status_t      status,
  output logic [lfe_pkg::QUEUE_CNT_W-1:0] count
);
  import lfe_pkg::*;

  lfe_entry_t             slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_PTR_W'(1);
      end
      count <= count + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  assign status.not_empty = count != '0;
  assign status.head      = slots[rd_ptr];

endmodule

FILE: rtl/lfe_back.sv
`timescale 1ns / 1ps

module lfe_back (
  input  logic                       clk,
  input  logic                       rst,
  input  lfe_pkg::lfe_queue_status_t status,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [31:0]                word,
  output logic [1:0]                 word_kind,
  output logic                       last_word
);
  import lfe_pkg::*;

  typedef enum logic [2:0] {
    ST_FIRST = 3'b001,
    ST_PIXEL = 3'b010,
    ST_END   = 3'b100
  } seq_state_t;

  seq_state_t  state;
  seq_state_t  state_next;
  logic        load;
  logic [31:0] word_next;
  logic [1:0]  kind_next;
  logic        last_next;

  assign load = status.not_empty && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    word_next  = status.head.pixel_word;
    kind_next  = KIND_PIXEL;
    last_next  = 1'b0;
    case (state)
      ST_FIRST: begin
        if (status.head.need_start) begin
          word_next  = START_WORD;
          kind_next  = KIND_START;
          state_next = ST_PIXEL;
        end else if (status.head.last) begin
          state_next = ST_END;
        end else begin
          pop = load;
        end
      end
      ST_PIXEL: begin
        if (status.head.last) begin
          state_next = ST_END;
        end else begin
          state_next = ST_FIRST;
          pop        = load;
        end
      end
      ST_END: begin
        word_next  = END_WORD;
        kind_next  = KIND_END;
        last_next  = 1'b1;
        state_next = ST_FIRST;
        pop        = load;
      end
      default: begin
        state_next = ST_FIRST;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_FIRST;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        state     <= state_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word      <= word_next;
      word_kind <= kind_next;
      last_word <= last_next;
    end
  end

endmodule

FILE: rtl/led_strip_frame_encoder.sv
`timescale 1ns / 1ps
// An accepted pixel passes the pipeline register, a queue slot and the sequencer's word
// register before its first word shows. Throughput: one pixel per cycle in a frame when
// out_stall is low; start and end words each take a turn of the single word register.
// A four-entry queue separates pixel processing from word sequencing.
// Reset (synchronous, active high) closes any open frame, empties the queue and
// restores brightness 31, normal byte order and full channel scales.

module led_strip_frame_encoder #(
  parameter int GAMMA_X100 = 280
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic [7:0]  alpha,
  input  logic        last_pixel,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] word,
  output logic [1:0]  word_kind,
  output logic        last_word,
  input  logic        cfg_en,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import lfe_pkg::*;

  logic                   push;
  lfe_entry_t             push_entry;
  logic                   pop;
  lfe_queue_status_t      status;
  logic [QUEUE_CNT_W-1:0] queue_count;

  lfe_front #(
    .GAMMA_X100(GAMMA_X100)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .alpha      (alpha),
    .last_pixel (last_pixel),
    .cfg_en     (cfg_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .queue_count(queue_count),
    .push       (push),
    .push_entry (push_entry)
  );

  lfe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .status    (status),
    .count     (queue_count)
  );

  lfe_back u_back (
    .clk      (clk),
    .rst      (rst),
    .status   (status),
    .pop      (pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .word     (word),
    .word_kind(word_kind),
    .last_word(last_word)
  );

endmodule

FILE: dv/tb_led_strip_frame_encoder.sv
`timescale 1ns / 1ps

module tb_led_strip_frame_encoder;
  import lfe_pkg::*;

  localparam int GAMMA_X100 = 280;
  localparam int IDLE_LIMIT = 2000;
  localparam logic [2:0] CFG_SPARE_LO = 3'd5;
  localparam logic [2:0] CFG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last;
  } pixel_t;

  typedef struct packed {
    logic [31:0] word;
    logic [1:0]  kind;
    logic        last;
  } led_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  red = 8'd0;
  logic [7:0]  green = 8'd0;
  logic [7:0]  blue = 8'd0;
  logic [7:0]  alpha = 8'd0;
  logic        last_pixel = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] word;
  logic [1:0]  word_kind;
  logic        last_word;
  logic        cfg_en = 1'b0;
  logic [2:0]  cfg_index = 3'd0;
  logic [7:0]  cfg_data = 8'd0;

  // Expected behavior of the encoder: its registers, its frame flag and the gamma fractions.
  logic [16:0] gamma_frac [256];
  logic [4:0]  model_brightness = BRIGHTNESS_RESET;
  logic        model_bridge = 1'b0;
  logic [7:0]  model_red_scale = SCALE_RESET;
  logic [7:0]  model_green_scale = SCALE_RESET;
  logic [7:0]  model_blue_scale = SCALE_RESET;
  logic        frame_open = 1'b0;

  pixel_t    pixel_queue [$];
  led_word_t pending_words [$];
  int        mismatch_count = 0;
  int        max_in_gap = 8;
  int        max_out_stall = 8;

  led_strip_frame_encoder #(
    .GAMMA_X100(GAMMA_X100)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .red(red),
    .green(green),
    .blue(blue),
    .alpha(alpha),
    .last_pixel(last_pixel),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .word(word),
    .word_kind(word_kind),
    .last_word(last_word),
    .cfg_en(cfg_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Fractions of 65536 for (c/255)^gamma, nearest integer.
  function automatic void fill_gamma_fractions();
    real expo;
    real frac;
    expo = real'(GAMMA_X100) / 100.0;
    for (int c = 0; c < 256; c++) begin
      if (c == 0) begin
        frac = 0.0;
      end else begin
        frac = $exp(expo * $ln(real'(c) / 255.0)) * 65536.0;
      end
      gamma_frac[c] = 17'($rtoi($floor(frac + 0.5)));
    end
  endfunction

  function automatic logic [7:0] corrected_channel(input logic [7:0] c, input logic [7:0] scale);
    logic [24:0] product;
    product = 25'(gamma_frac[c]) * 25'(scale);
    return product[23:16];
  endfunction

  function automatic void push_word(input logic [31:0] w, input logic [1:0] kind,
                                    input logic last);
    led_word_t lw;
    lw.word = model_bridge ? {w[23:0], w[31:24]} : w;
    lw.kind = kind;
    lw.last = last;
    pending_words.push_back(lw);
  endfunction

  function automatic void encode_pixel(input pixel_t px);
    logic [12:0] product;
    logic [4:0]  bright;
    if (!frame_open) begin
      push_word(START_WORD, KIND_START, 1'b0);
      frame_open = 1'b1;
    end
    product = 13'(px.alpha) * 13'(model_brightness);
    bright = 5'(product / 13'd255);
    push_word({HEADER_MARK | {3'b000, bright},
               corrected_channel(px.blue, model_blue_scale),
               corrected_channel(px.green, model_green_scale),
               corrected_channel(px.red, model_red_scale)}, KIND_PIXEL, 1'b0);
    if (px.last) begin
      push_word(END_WORD, KIND_END, 1'b1);
      frame_open = 1'b0;
    end
  endfunction

  // Sender: one pixel transfer at a time, with a random gap after each.
  always @(posedge clk) begin
    pixel_t nxt;
    int gap_left;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        encode_pixel({red, green, blue, alpha, last_pixel});
        gap_left = $urandom_range(0, max_in_gap);
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pixel_queue.size() != 0) begin
          nxt = pixel_queue.pop_front();
          in_valid <= 1'b1;
          red <= nxt.red;
          green <= nxt.green;
          blue <= nxt.blue;
          alpha <= nxt.alpha;
          last_pixel <= nxt.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks every word transfer and stalls at random between them.
  always @(posedge clk) begin
    led_word_t exp_w;
    int stall_left;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word %h kind %0d last %0b",
                                    word, word_kind, last_word));
        end else begin
          exp_w = pending_words.pop_front();
          if (word !== exp_w.word)
            report_mismatch($sformatf("word %h, expected %h", word, exp_w.word));
          if (word_kind !== exp_w.kind)
            report_mismatch($sformatf("word_kind %0d, expected %0d", word_kind, exp_w.kind));
          if (last_word !== exp_w.last)
            report_mismatch($sformatf("last_word %0b, expected %0b", last_word, exp_w.last));
        end
        stall_left = $urandom_range(0, max_out_stall);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0);
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_en || rst) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Test completed with failures");
    $finish;
  end

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
    @(posedge clk);
    cfg_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_en <= 1'b0;
    case (idx)
      CFG_GLOBAL_BRIGHTNESS: model_brightness = data[4:0];
      CFG_BRIDGE_ORDER:      model_bridge = data[0];
      CFG_RED_SCALE:         model_red_scale = data;
      CFG_GREEN_SCALE:       model_green_scale = data;
      CFG_BLUE_SCALE:        model_blue_scale = data;
      default: ;
    endcase
  endtask

  // Waits until every queued pixel has been sent and every expected word has come out.
  task automatic wait_for_drain();
    while (pixel_queue.size() != 0 || in_valid || pending_words.size() != 0)
      @(posedge clk);
  endtask

  task automatic queue_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                             input logic [7:0] a, input logic last);
    pixel_t px;
    px.red = r;
    px.green = g;
    px.blue = b;
    px.alpha = a;
    px.last = last;
    pixel_queue.push_back(px);
  endtask

  // Extremes come up often enough to hit the ends of every channel.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic queue_run(input int len, input logic close);
    for (int i = 0; i < len; i++)
      queue_pixel(pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                  close && (i == len - 1));
  endtask

  initial begin : stimulus
    int phase_items;
    int len;
    fill_gamma_fractions();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: single-pixel frames and a short frame over the field extremes.
    queue_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
    queue_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    queue_pixel(8'h01, 8'h80, 8'hFE, 8'h01, 1'b0);
    queue_pixel(8'h80, 8'h01, 8'hFF, 8'hFE, 1'b0);
    queue_pixel(8'hFF, 8'h00, 8'h00, 8'h80, 1'b1);
    queue_pixel(8'h00, 8'hFF, 8'h00, 8'hFF, 1'b0);
    wait_for_drain();

    // Settings changed while a frame is open apply from the next pixel on.
    write_reg(CFG_BRIDGE_ORDER, 8'h01);
    write_reg(CFG_GLOBAL_BRIGHTNESS, 8'h00);
    queue_pixel(8'h00, 8'h00, 8'hFF, 8'hFF, 1'b1);
    wait_for_drain();

    write_reg(CFG_RED_SCALE, 8'h00);
    write_reg(CFG_GREEN_SCALE, 8'h00);
    write_reg(CFG_BLUE_SCALE, 8'h00);
    for (int i = int'(CFG_SPARE_LO); i <= int'(CFG_SPARE_HI); i++)
      write_reg(3'(i), 8'($urandom));
    queue_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    queue_pixel(8'hAA, 8'h55, 8'h33, 8'hCC, 1'b1);
    wait_for_drain();

    // Upper data bits of the narrow registers must be dropped.
    write_reg(CFG_GLOBAL_BRIGHTNESS, 8'hFF);
    write_reg(CFG_BRIDGE_ORDER, 8'hFE);
    write_reg(CFG_RED_SCALE, 8'hFF);
    write_reg(CFG_GREEN_SCALE, 8'h80);
    write_reg(CFG_BLUE_SCALE, 8'h01);
    queue_pixel(8'h55, 8'hAA, 8'hCC, 8'h33, 1'b0);
    queue_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    wait_for_drain();
    write_reg(CFG_BRIDGE_ORDER, 8'h01);
    queue_pixel(8'h12, 8'hED, 8'h7F, 8'h80, 1'b1);
    wait_for_drain();

    for (int phase = 0; phase < 10; phase++) begin
      write_reg(CFG_GLOBAL_BRIGHTNESS, pick_byte());
      write_reg(CFG_BRIDGE_ORDER, 8'($urandom));
      write_reg(CFG_RED_SCALE, pick_byte());
      write_reg(CFG_GREEN_SCALE, pick_byte());
      write_reg(CFG_BLUE_SCALE, pick_byte());
      if ($urandom_range(0, 3) == 0)
        write_reg(3'($urandom_range(int'(CFG_SPARE_LO), int'(CFG_SPARE_HI))), pick_byte());
      max_in_gap = ($urandom_range(0, 2) == 0) ? 0 : 8;
      max_out_stall = ($urandom_range(0, 2) == 0) ? 0 : 8;
      phase_items = 0;
      while (phase_items < 12) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 5);
        queue_run(len, 1'b1);
        phase_items += len;
      end
      // Sometimes leave a frame open across the settings change.
      if (phase != 9 && $urandom_range(0, 2) == 0)
        queue_run($urandom_range(1, 3), 1'b0);
      wait_for_drain();
    end

    repeat (10) @(posedge clk);
    if (pending_words.size() != 0)
      report_mismatch($sformatf("%0d expected words never came", pending_words.size()));
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: led_strip_frame_encoder.f
rtl/lfe_pkg.sv
rtl/lfe_front.sv
rtl/lfe_queue.sv
rtl/lfe_back.sv
rtl/led_strip_frame_encoder.sv
dv/tb_led_strip_frame_encoder.sv
